[rtl/core/bfc_pkg.sv]
// shared types and constants for the box frustum culling block
`default_nettype none

package bfc_pkg;

   // field and datapath widths
   localparam int COORD_W        = 16;
   localparam int PLANE_W        = 64;
   localparam int PROD_W         = 32;
   localparam int ABS_W          = 17;
   localparam int RAD_W          = 33;
   localparam int SUM_W          = 36;
   localparam int COUNT_W        = 17;
   localparam int SLOT_W         = 16;
   localparam int INDEX_W        = 16;
   localparam int D_SHIFT        = 14;

   // plane register file
   localparam int NUM_PLANE_REGS = 6;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;

   // parameter defaults
   localparam int PLANE_COUNT_DEF = 6;
   localparam int MAX_BATCH_DEF   = 65536;

   // bit positions of the plane fields
   localparam int PLANE_A_LSB = 48;
   localparam int PLANE_B_LSB = 32;
   localparam int PLANE_C_LSB = 16;
   localparam int PLANE_D_LSB = 0;

   typedef struct packed {
      logic        [INDEX_W-1:0] item_index;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic signed [COORD_W-1:0] size_x;
      logic signed [COORD_W-1:0] size_y;
      logic signed [COORD_W-1:0] size_z;
      logic                      last_item;
   } bfc_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] box_index;
      logic               visible;
      logic [SLOT_W-1:0]  out_slot;
      logic [COUNT_W-1:0] visible_total;
      logic               batch_done;
   } bfc_rsp_type;

endpackage

`default_nettype wire

[rtl/core/box_frustum_cull.sv]
// top level: axis-aligned box versus plane frustum culling with visible-list compaction
//
//   channel  direction  handshake              contents
//   req      in         req_valid / req_stall  one box: index, center, sizes, last flag
//   rsp      out        rsp_valid / rsp_stall  index, visible flag, slot, running total, done
//   csr      in         csr_valid / csr_ready  plane register index and 64-bit plane value
//
// one word is accepted per cycle while req_stall is low; its result is carried through
// the input register, product register, plane test register and result register
// the pipeline stages advance independently, so bubbles close up behind a stalled result
// the visible count is the only link between words and updates in the result stage
// reset clears the plane registers, the visible count and all stage valid bits
`default_nettype none

module box_frustum_cull #(
   parameter int PLANE_COUNT = bfc_pkg::PLANE_COUNT_DEF,
   parameter int MAX_BATCH   = bfc_pkg::MAX_BATCH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   // box input
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  bfc_pkg::bfc_req_type         req_data,
   // result output
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output bfc_pkg::bfc_rsp_type               rsp_data,
   // plane register writes
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [bfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [bfc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COORD_W = bfc_pkg::COORD_W;
   localparam int PROD_W  = bfc_pkg::PROD_W;
   localparam int ABS_W   = bfc_pkg::ABS_W;
   localparam int RAD_W   = bfc_pkg::RAD_W;
   localparam int SUM_W   = bfc_pkg::SUM_W;
   localparam int COUNT_W = bfc_pkg::COUNT_W;
   localparam int SLOT_W  = bfc_pkg::SLOT_W;
   localparam int INDEX_W = bfc_pkg::INDEX_W;

   // plane registers
   logic [bfc_pkg::PLANE_W-1:0] plane_ff [bfc_pkg::NUM_PLANE_REGS];

   // stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_ready, s2_ready, s3_ready, out_ready;

   // stage payloads
   bfc_pkg::bfc_req_type       s1_box_ff;
   logic [INDEX_W-1:0]         s2_index_ff, s3_index_ff;
   logic                       s2_last_ff, s3_last_ff;
   logic signed [PROD_W-1:0]   dist_prod_ff [PLANE_COUNT][3];
   logic signed [RAD_W-1:0]    rad_prod_ff  [PLANE_COUNT][3];
   logic [PLANE_COUNT-1:0]     pass_in, pass_ff;
   bfc_pkg::bfc_rsp_type       rsp_ff, rsp_in;

   // visible count
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [COUNT_W-1:0]         count_after;
   logic                       box_visible;
   logic [SLOT_W-1:0]          slot;

   // ready chain: a stage takes a word when empty or when it hands its own word on
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign csr_ready = 1'b1;

   // plane register writes, indexes past the register file are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bfc_pkg::NUM_PLANE_REGS; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready &&
                   (csr_index < bfc_pkg::CSR_INDEX_W'(bfc_pkg::NUM_PLANE_REGS))) begin
         plane_ff[csr_index] <= csr_data;
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (out_ready) out_valid_ff <= s3_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_box_ff <= req_data;
      end
   end

   // per-plane lanes: products, then the signed plane test
   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      logic signed [COORD_W-1:0] a_s, b_s, c_s, d_s;
      logic signed [ABS_W-1:0]   abs_a, abs_b, abs_c;
      logic signed [SUM_W-1:0]   dist_sum, total;

      assign a_s = $signed(plane_ff[p][bfc_pkg::PLANE_A_LSB +: COORD_W]);
      assign b_s = $signed(plane_ff[p][bfc_pkg::PLANE_B_LSB +: COORD_W]);
      assign c_s = $signed(plane_ff[p][bfc_pkg::PLANE_C_LSB +: COORD_W]);
      assign d_s = $signed(plane_ff[p][bfc_pkg::PLANE_D_LSB +: COORD_W]);

      assign abs_a = a_s[COORD_W-1] ? -(ABS_W'(a_s)) : ABS_W'(a_s);
      assign abs_b = b_s[COORD_W-1] ? -(ABS_W'(b_s)) : ABS_W'(b_s);
      assign abs_c = c_s[COORD_W-1] ? -(ABS_W'(c_s)) : ABS_W'(c_s);

      // product register
      always_ff @(posedge clock) begin
         if (s2_ready) begin
            dist_prod_ff[p][0] <= PROD_W'(a_s) * PROD_W'(s1_box_ff.center_x);
            dist_prod_ff[p][1] <= PROD_W'(b_s) * PROD_W'(s1_box_ff.center_y);
            dist_prod_ff[p][2] <= PROD_W'(c_s) * PROD_W'(s1_box_ff.center_z);
            rad_prod_ff[p][0]  <= RAD_W'(abs_a) * RAD_W'(s1_box_ff.size_x);
            rad_prod_ff[p][1]  <= RAD_W'(abs_b) * RAD_W'(s1_box_ff.size_y);
            rad_prod_ff[p][2]  <= RAD_W'(abs_c) * RAD_W'(s1_box_ff.size_z);
         end
      end

      // doubled distance plus radius, the box survives this plane when it is not negative
      assign dist_sum = SUM_W'(dist_prod_ff[p][0]) + SUM_W'(dist_prod_ff[p][1])
                      + SUM_W'(dist_prod_ff[p][2]) + (SUM_W'(d_s) <<< bfc_pkg::D_SHIFT);
      assign total = (dist_sum <<< 1) + SUM_W'(rad_prod_ff[p][0])
                   + SUM_W'(rad_prod_ff[p][1]) + SUM_W'(rad_prod_ff[p][2]);
      assign pass_in[p] = !total[SUM_W-1];
   end

   // side data alongside the product and test registers
   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_index_ff <= s1_box_ff.item_index;
         s2_last_ff  <= s1_box_ff.last_item;
      end
      if (s3_ready) begin
         s3_index_ff <= s2_index_ff;
         s3_last_ff  <= s2_last_ff;
         pass_ff     <= pass_in;
      end
   end

   // result stage: visibility, slot assignment and saturating count, cleared by the last box
   always_comb begin
      box_visible = &pass_ff;
      slot        = '0;
      count_after = count_ff;
      if (box_visible) begin
         slot = count_ff[COUNT_W-1] ? {SLOT_W{1'b1}} : count_ff[SLOT_W-1:0];
         if (count_ff < COUNT_W'(MAX_BATCH)) begin
            count_after = count_ff + COUNT_W'(1);
         end
      end
      count_in = s3_last_ff ? '0 : count_after;

      rsp_in.box_index     = s3_index_ff;
      rsp_in.visible       = box_visible;
      rsp_in.out_slot      = slot;
      rsp_in.visible_total = count_after;
      rsp_in.batch_done    = s3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (out_ready && s3_valid_ff) begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_BATCH))
      else $error("visible count above batch limit");

   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      (out_ready && s3_valid_ff && s3_last_ff) |=> (count_ff == '0))
      else $error("visible count not cleared after last box");

   a_culled_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.visible) |-> (rsp_data.out_slot == '0))
      else $error("culled box carries a slot");

   a_total_follows_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.visible) |->
         ((rsp_data.visible_total == (COUNT_W'(rsp_data.out_slot) + COUNT_W'(1))) ||
          (rsp_data.visible_total == COUNT_W'(MAX_BATCH))))
      else $error("visible total does not follow slot");

endmodule

`default_nettype wire
